// ===== hw/rtl/rcs_pkg.sv =====
package rcs_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int COST_W    = 38;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_CHOOSE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STRAT_AREA     = 2'd0,
    STRAT_OVERLAP  = 2'd1,
    STRAT_MARGIN   = 2'd2,
    STRAT_AREA_ALT = 2'd3
  } strat_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/rtree_choose_subtree.sv =====
// Append, clear and unknown requests go straight to the done state, which loads the output register.
// Choose with N entries prices the entries one after another (overlap walks all N entries for each),
// paced by the one shared multiplier and the single read port of the entry memory.
// One request at a time; the next is taken once the result sits in the output register.
// Reset (async, active low) empties the table, selects the area cost and idles
// the sequencer; entry memory contents stay undefined until appended.
module rtree_choose_subtree #(
  parameter int MAX_ENTRIES = rcs_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = rcs_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic signed [COORD_BITS-1:0]     rect_min_x_i,
  input  logic signed [COORD_BITS-1:0]     rect_min_y_i,
  input  logic signed [COORD_BITS-1:0]     rect_max_x_i,
  input  logic signed [COORD_BITS-1:0]     rect_max_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rcs_pkg::IDX_OUT_W-1:0]    best_index_o,
  output logic [rcs_pkg::COST_W-1:0]       best_cost_o,
  output logic [1:0]                       status_o,
  output logic [rcs_pkg::CNT_OUT_W-1:0]    entry_count_o
);

  localparam int W      = COORD_BITS;
  localparam int BOX_W  = 4 * W;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W = 2 * W;
  localparam int COST_W = rcs_pkg::COST_W;
  localparam int EXT_W  = ((PROD_W > COST_W) ? PROD_W : COST_W) + 1;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_RD_I    = 12'b0000_0000_0010,
    S_UNION   = 12'b0000_0000_0100,
    S_MUL_U   = 12'b0000_0000_1000,
    S_MUL_E   = 12'b0000_0001_0000,
    S_RD_J    = 12'b0000_0010_0000,
    S_OVL     = 12'b0000_0100_0000,
    S_OVL_MUL = 12'b0000_1000_0000,
    S_ACC     = 12'b0001_0000_0000,
    S_EVAL    = 12'b0010_0000_0000,
    S_CMP     = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  function automatic logic [COST_W-1:0] sat_cost(input logic [EXT_W-1:0] v);
    return (v > EXT_W'(rcs_pkg::COST_MAX)) ? rcs_pkg::COST_MAX : v[COST_W-1:0];
  endfunction

  function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_e              state_q, state_d;
  rcs_pkg::strat_e     strat_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    i_q, i_d, j_q, j_d;

  logic signed [W-1:0] q_x0_q, q_y0_q, q_x1_q, q_y1_q;
  logic signed [W-1:0] q_x0_d, q_y0_d, q_x1_d, q_y1_d;
  logic signed [W-1:0] u_x0_q, u_y0_q, u_x1_q, u_y1_q;
  logic signed [W-1:0] u_x0_d, u_y0_d, u_x1_d, u_y1_d;
  logic [W-1:0]        uw_q, uh_q, ew_q, eh_q, ow_q, oh_q;
  logic [W-1:0]        uw_d, uh_d, ew_d, eh_d, ow_d, oh_d;
  logic [PROD_W-1:0]   mul_q, mul_d, au_q, au_d;
  logic [COST_W-1:0]   acc_q, acc_d, cost_q, cost_d;
  logic [COST_W-1:0]   best_cost_q, best_cost_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  rcs_pkg::status_e    status_q, status_d;

  logic                            out_valid_q, out_valid_d;
  logic [rcs_pkg::IDX_OUT_W-1:0]   out_idx_q, out_idx_d;
  logic [COST_W-1:0]               out_cost_q, out_cost_d;
  logic [1:0]                      out_status_q, out_status_d;
  logic [rcs_pkg::CNT_OUT_W-1:0]   out_count_q, out_count_d;

  // entry memory, one write and one registered read port
  logic [BOX_W-1:0]    mem [MAX_ENTRIES];
  logic [BOX_W-1:0]    rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;

  logic signed [W-1:0] in_x0, in_y0, in_x1, in_y1;
  logic [BOX_W-1:0]    in_box;
  logic signed [W-1:0] e_x0, e_y0, e_x1, e_y1;
  logic signed [W-1:0] un_x0, un_y0, un_x1, un_y1;
  logic signed [W:0]   uw_full, uh_full, ew_full, eh_full;
  logic signed [W-1:0] o_x0, o_y0, o_x1, o_y1;
  logic signed [W:0]   ow_full, oh_full;
  logic                ovl_hit;
  logic [W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   area_diff;
  logic [COST_W-1:0]   mul_sat, eval_cost;
  logic                full, last_i, last_j;

  assign in_stall_o = (state_q != S_IDLE);

  // normalize: swap inverted edges
  assign in_x0  = (rect_min_x_i > rect_max_x_i) ? rect_max_x_i : rect_min_x_i;
  assign in_x1  = (rect_min_x_i > rect_max_x_i) ? rect_min_x_i : rect_max_x_i;
  assign in_y0  = (rect_min_y_i > rect_max_y_i) ? rect_max_y_i : rect_min_y_i;
  assign in_y1  = (rect_min_y_i > rect_max_y_i) ? rect_min_y_i : rect_max_y_i;
  assign in_box = {in_x0, in_y0, in_x1, in_y1};

  assign full   = (count_q >= CNT_W'(MAX_ENTRIES));
  assign mem_we = (state_q == S_IDLE) && in_valid_i &&
                  (rcs_pkg::req_e'(req_type_i) == rcs_pkg::REQ_APPEND) && !full;
  assign rd_addr = (state_q == S_RD_J) ? j_q : i_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDX_W-1:0]] <= in_box;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign e_x0 = $signed(rd_data_q[4*W-1 -: W]);
  assign e_y0 = $signed(rd_data_q[3*W-1 -: W]);
  assign e_x1 = $signed(rd_data_q[2*W-1 -: W]);
  assign e_y1 = $signed(rd_data_q[W-1 -: W]);

  // union of the fetched entry with the query
  assign un_x0   = smin(e_x0, q_x0_q);
  assign un_y0   = smin(e_y0, q_y0_q);
  assign un_x1   = smax(e_x1, q_x1_q);
  assign un_y1   = smax(e_y1, q_y1_q);
  assign uw_full = {un_x1[W-1], un_x1} - {un_x0[W-1], un_x0};
  assign uh_full = {un_y1[W-1], un_y1} - {un_y0[W-1], un_y0};
  assign ew_full = {e_x1[W-1], e_x1} - {e_x0[W-1], e_x0};
  assign eh_full = {e_y1[W-1], e_y1} - {e_y0[W-1], e_y0};

  // overlap of the held union with the fetched entry j
  assign o_x0    = smax(u_x0_q, e_x0);
  assign o_y0    = smax(u_y0_q, e_y0);
  assign o_x1    = smin(u_x1_q, e_x1);
  assign o_y1    = smin(u_y1_q, e_y1);
  assign ow_full = {o_x1[W-1], o_x1} - {o_x0[W-1], o_x0};
  assign oh_full = {o_y1[W-1], o_y1} - {o_y0[W-1], o_y0};
  assign ovl_hit = !ow_full[W] && (ow_full != '0) && !oh_full[W] && (oh_full != '0) &&
                   (j_q != i_q);

  // shared multiplier
  always_comb begin
    case (state_q)
      S_MUL_U: begin
        mul_a = uw_q;
        mul_b = uh_q;
      end
      S_MUL_E: begin
        mul_a = ew_q;
        mul_b = eh_q;
      end
      default: begin
        mul_a = ow_q;
        mul_b = oh_q;
      end
    endcase
  end

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign area_diff = au_q - mul_q;
  assign mul_sat   = sat_cost(EXT_W'(mul_q));

  always_comb begin
    case (strat_q)
      rcs_pkg::STRAT_OVERLAP: eval_cost = acc_q;
      rcs_pkg::STRAT_MARGIN:  eval_cost = sat_cost((EXT_W'(uw_q) + EXT_W'(uh_q)) << 1);
      default:                eval_cost = sat_cost(EXT_W'(area_diff));
    endcase
  end

  assign last_i = ((CNT_W'(i_q) + CNT_W'(1)) == count_q);
  assign last_j = ((CNT_W'(j_q) + CNT_W'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    q_x0_d      = q_x0_q;
    q_y0_d      = q_y0_q;
    q_x1_d      = q_x1_q;
    q_y1_d      = q_y1_q;
    u_x0_d      = u_x0_q;
    u_y0_d      = u_y0_q;
    u_x1_d      = u_x1_q;
    u_y1_d      = u_y1_q;
    uw_d        = uw_q;
    uh_d        = uh_q;
    ew_d        = ew_q;
    eh_d        = eh_q;
    ow_d        = ow_q;
    oh_d        = oh_q;
    mul_d       = mul_q;
    au_d        = au_q;
    acc_d       = acc_q;
    cost_d      = cost_q;
    best_cost_d = best_cost_q;
    best_idx_d  = best_idx_q;
    status_d    = status_q;
    out_idx_d    = out_idx_q;
    out_cost_d   = out_cost_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          best_idx_d  = '0;
          best_cost_d = '0;
          status_d    = rcs_pkg::ST_OK;
          state_d     = S_DONE;
          case (rcs_pkg::req_e'(req_type_i))
            rcs_pkg::REQ_APPEND: begin
              if (full) begin
                status_d = rcs_pkg::ST_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            rcs_pkg::REQ_CHOOSE: begin
              if (count_q == '0) begin
                status_d = rcs_pkg::ST_EMPTY;
              end else begin
                q_x0_d  = in_x0;
                q_y0_d  = in_y0;
                q_x1_d  = in_x1;
                q_y1_d  = in_y1;
                i_d     = '0;
                state_d = S_RD_I;
              end
            end
            rcs_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_I: begin
        state_d = S_UNION;
      end
      S_UNION: begin
        u_x0_d = un_x0;
        u_y0_d = un_y0;
        u_x1_d = un_x1;
        u_y1_d = un_y1;
        uw_d   = uw_full[W-1:0];
        uh_d   = uh_full[W-1:0];
        ew_d   = ew_full[W-1:0];
        eh_d   = eh_full[W-1:0];
        case (strat_q)
          rcs_pkg::STRAT_OVERLAP: begin
            j_d     = '0;
            acc_d   = '0;
            state_d = S_RD_J;
          end
          rcs_pkg::STRAT_MARGIN: state_d = S_EVAL;
          default:               state_d = S_MUL_U;
        endcase
      end
      S_MUL_U: begin
        mul_d   = mul_p;
        state_d = S_MUL_E;
      end
      S_MUL_E: begin
        au_d    = mul_q;
        mul_d   = mul_p;
        state_d = S_EVAL;
      end
      S_RD_J: begin
        state_d = S_OVL;
      end
      S_OVL: begin
        // drop the entry itself and disjoint or touching pairs
        ow_d    = ovl_hit ? ow_full[W-1:0] : '0;
        oh_d    = ovl_hit ? oh_full[W-1:0] : '0;
        state_d = S_OVL_MUL;
      end
      S_OVL_MUL: begin
        mul_d   = mul_p;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = sat_cost(EXT_W'(acc_q) + EXT_W'(mul_sat));
        if (last_j) begin
          state_d = S_EVAL;
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = S_RD_J;
        end
      end
      S_EVAL: begin
        cost_d  = eval_cost;
        state_d = S_CMP;
      end
      S_CMP: begin
        // strict less keeps the lowest index on ties
        if ((i_q == '0) || (cost_q < best_cost_q)) begin
          best_cost_d = cost_q;
          best_idx_d  = i_q;
        end
        if (last_i) begin
          state_d = S_DONE;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_RD_I;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_idx_d    = rcs_pkg::IDX_OUT_W'(best_idx_q);
          out_cost_d   = best_cost_q;
          out_status_d = status_q;
          out_count_d  = rcs_pkg::CNT_OUT_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strat_q     <= rcs_pkg::STRAT_AREA;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        strat_q <= rcs_pkg::strat_e'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_x0_q       <= q_x0_d;
    q_y0_q       <= q_y0_d;
    q_x1_q       <= q_x1_d;
    q_y1_q       <= q_y1_d;
    u_x0_q       <= u_x0_d;
    u_y0_q       <= u_y0_d;
    u_x1_q       <= u_x1_d;
    u_y1_q       <= u_y1_d;
    uw_q         <= uw_d;
    uh_q         <= uh_d;
    ew_q         <= ew_d;
    eh_q         <= eh_d;
    ow_q         <= ow_d;
    oh_q         <= oh_d;
    mul_q        <= mul_d;
    au_q         <= au_d;
    acc_q        <= acc_d;
    cost_q       <= cost_d;
    best_cost_q  <= best_cost_d;
    best_idx_q   <= best_idx_d;
    status_q     <= status_d;
    out_idx_q    <= out_idx_d;
    out_cost_q   <= out_cost_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign best_index_o  = out_idx_q;
  assign best_cost_o   = out_cost_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_cmp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (CNT_W'(i_q) < count_q))
    else $error("priced entry beyond held entries");

  a_ovl_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OVL) |-> (CNT_W'(j_q) < count_q))
    else $error("overlap partner beyond held entries");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == rcs_pkg::ST_FULL) |->
      (count_q == CNT_W'(MAX_ENTRIES)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == rcs_pkg::ST_EMPTY) |->
      (count_q == '0 && best_cost_q == '0 && best_idx_q == '0))
    else $error("empty status with a nonzero result");
`endif

endmodule

// ===== bench/rtree_choose_subtree_tb.sv =====
module rtree_choose_subtree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcs_pkg::*;

  localparam int CW    = COORD_BITS_DEF;
  localparam int SLOTS = MAX_ENTRIES_DEF;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_LO = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_HI = {1'b0, {(CW-1){1'b1}}};

  typedef struct {
    req_e   kind;
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } request_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] best_index;
    logic [COST_W-1:0]    best_cost;
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
  } choice_t;

  typedef struct {
    longint x0;
    longint y0;
    longint x1;
    longint y1;
  } box_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           req_type_i;
  coord_t               rect_min_x_i;
  coord_t               rect_min_y_i;
  coord_t               rect_max_x_i;
  coord_t               rect_max_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [IDX_OUT_W-1:0] best_index_o;
  logic [COST_W-1:0]    best_cost_o;
  logic [1:0]           status_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Predictor state
  box_t        held_boxes [SLOTS];
  int unsigned held_count = 0;
  strat_e      cost_mode = STRAT_AREA;

  choice_t     pending_choices [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  rtree_choose_subtree uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .rect_min_x_i  (rect_min_x_i),
    .rect_min_y_i  (rect_min_y_i),
    .rect_max_x_i  (rect_max_x_i),
    .rect_max_y_i  (rect_max_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_index_o  (best_index_o),
    .best_cost_o   (best_cost_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] clip_cost(logic [63:0] v);
    return (v > 64'(COST_MAX)) ? 64'(COST_MAX) : v;
  endfunction

  function automatic logic [63:0] box_area(box_t b);
    return (b.x1 - b.x0) * (b.y1 - b.y0);
  endfunction

  function automatic logic [63:0] overlap_area(box_t a, box_t b);
    longint w;
    longint h;
    w = ((a.x1 < b.x1) ? a.x1 : b.x1) - ((a.x0 > b.x0) ? a.x0 : b.x0);
    h = ((a.y1 < b.y1) ? a.y1 : b.y1) - ((a.y0 > b.y0) ? a.y0 : b.y0);
    if (w <= 0 || h <= 0) return 64'd0;
    return w * h;
  endfunction

  function automatic box_t to_box(request_t r);
    box_t   b;
    longint t;
    b.x0 = longint'(r.min_x);
    b.y0 = longint'(r.min_y);
    b.x1 = longint'(r.max_x);
    b.y1 = longint'(r.max_y);
    // Swap inverted edges
    if (b.x0 > b.x1) begin
      t = b.x0; b.x0 = b.x1; b.x1 = t;
    end
    if (b.y0 > b.y1) begin
      t = b.y0; b.y0 = b.y1; b.y1 = t;
    end
    return b;
  endfunction

  function automatic logic [63:0] insertion_cost(int unsigned i, box_t q);
    box_t        e;
    box_t        u;
    logic [63:0] acc;
    int unsigned j;
    e = held_boxes[i];
    u.x0 = (e.x0 < q.x0) ? e.x0 : q.x0;
    u.y0 = (e.y0 < q.y0) ? e.y0 : q.y0;
    u.x1 = (e.x1 > q.x1) ? e.x1 : q.x1;
    u.y1 = (e.y1 > q.y1) ? e.y1 : q.y1;
    acc = '0;
    case (cost_mode)
      STRAT_OVERLAP: begin
        for (j = 0; j < held_count; j++) begin
          if (j != i) acc = clip_cost(acc + clip_cost(overlap_area(u, held_boxes[j])));
        end
      end
      STRAT_MARGIN: acc = clip_cost(2 * ((u.x1 - u.x0) + (u.y1 - u.y0)));
      default:      acc = clip_cost(box_area(u) - box_area(e));
    endcase
    return acc;
  endfunction

  function automatic choice_t predict_choice(request_t r);
    choice_t     c;
    box_t        q;
    logic [63:0] price;
    int unsigned i;
    c.best_index = '0;
    c.best_cost  = '0;
    c.status     = ST_OK;
    q = to_box(r);
    case (r.kind)
      REQ_APPEND: begin
        if (held_count >= SLOTS) begin
          c.status = ST_FULL;
        end else begin
          held_boxes[held_count] = q;
          held_count++;
        end
      end
      REQ_CHOOSE: begin
        if (held_count == 0) begin
          c.status = ST_EMPTY;
        end else begin
          c.best_cost = COST_W'(insertion_cost(0, q));
          // Strict compare keeps the lowest index on ties
          for (i = 1; i < held_count; i++) begin
            price = insertion_cost(i, q);
            if (price < 64'(c.best_cost)) begin
              c.best_cost  = COST_W'(price);
              c.best_index = IDX_OUT_W'(i);
            end
          end
        end
      end
      REQ_CLEAR: held_count = 0;
      default: ;
    endcase
    c.count = CNT_OUT_W'(held_count);
    return c;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    choice_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_choices.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_choices.pop_front();
        if (best_index_o !== want.best_index) begin
          $error("best_index: expected %0d, got %0d", want.best_index, best_index_o);
          mismatches++;
        end
        if (best_cost_o !== want.best_cost) begin
          $error("best_cost: expected %0d, got %0d", want.best_cost, best_cost_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic request_t make_request(req_e kind, coord_t x0, coord_t y0,
                                            coord_t x1, coord_t y1);
    request_t r;
    r.kind  = kind;
    r.min_x = x0;
    r.min_y = y0;
    r.max_x = x1;
    r.max_y = y1;
    return r;
  endfunction

  function automatic coord_t random_coord();
    coord_t c;
    case ($urandom_range(0, 9))
      0:       c = COORD_LO;
      1:       c = COORD_HI;
      2, 3:    c = coord_t'($urandom);
      default: begin
        // Cluster near the origin so rectangles overlap
        c = coord_t'(int'($urandom_range(0, 600)) - 300);
      end
    endcase
    return c;
  endfunction

  function automatic request_t random_rect(req_e kind);
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
    a = random_coord();
    b = random_coord();
    c = random_coord();
    d = random_coord();
    if ($urandom_range(0, 4) == 0) return make_request(kind, a, c, b, d);
    return make_request(kind, (a < b) ? a : b, (c < d) ? c : d,
                        (a < b) ? b : a, (c < d) ? d : c);
  endfunction

  task automatic send_request(input request_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= r.kind;
    rect_min_x_i <= r.min_x;
    rect_min_y_i <= r.min_y;
    rect_max_x_i <= r.max_x;
    rect_max_y_i <= r.max_y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_choices.insert(pending_choices.size(), predict_choice(r));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_choices.size() != 0);
  endtask

  task automatic write_strategy(input strat_e mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cost_mode = mode;
  endtask

  task automatic test_edge_cases();
    send_request(make_request(REQ_CHOOSE, 0, 0, 1, 1));
    send_request(make_request(REQ_NOP, -1, -1, -1, -1));
    send_request(make_request(REQ_APPEND, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
    send_request(make_request(REQ_CHOOSE, 10, 10, 20, 20));
    send_request(make_request(REQ_APPEND, 100, 50, -100, -50));
    send_request(make_request(REQ_CHOOSE, 300, -20, 200, -40));
    send_request(make_request(REQ_APPEND, COORD_HI, COORD_HI, COORD_HI, COORD_HI));
    send_request(make_request(REQ_APPEND, COORD_LO, COORD_LO, COORD_LO, COORD_LO));
    send_request(make_request(REQ_CHOOSE, COORD_HI, COORD_LO, COORD_HI, COORD_LO));
    send_request(make_request(REQ_NOP, COORD_HI, COORD_HI, COORD_LO, COORD_LO));
  endtask

  task automatic test_full_table();
    repeat (SLOTS - held_count) send_request(random_rect(REQ_APPEND));
    send_request(random_rect(REQ_APPEND));
    wait_for_results();
    write_strategy(STRAT_OVERLAP);
    send_request(make_request(REQ_CHOOSE, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
    send_request(make_request(REQ_CLEAR, 0, 0, 0, 0));
    send_request(make_request(REQ_CHOOSE, -5, -5, 5, 5));
  endtask

  task automatic run_random_mix(input int unsigned item_goal);
    int unsigned sent;
    int unsigned fill;
    int unsigned picks;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 9) < 8) begin
        send_request(random_rect(REQ_CLEAR));
        sent++;
      end
      // Mostly small tables; now and then run past full
      fill = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
      repeat (fill) send_request(random_rect(REQ_APPEND));
      picks = $urandom_range(1, 4);
      repeat (picks) send_request(random_rect(REQ_CHOOSE));
      sent += fill + picks;
      if ($urandom_range(0, 9) == 0) begin
        send_request(random_rect(req_e'($urandom_range(0, 3))));
        sent++;
      end
      // Hold the sender until the block drains
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned sender_pct [3];
    int unsigned receiver_pct [3];
    strat_e      modes [4];
    sender_pct   = '{33, 68, 0};
    receiver_pct = '{68, 33, 0};
    modes        = '{STRAT_OVERLAP, STRAT_MARGIN, STRAT_AREA_ALT, STRAT_AREA};
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 4; s++) begin
        wait_for_results();
        send_idle_pct  = sender_pct[p];
        recv_stall_pct = receiver_pct[p];
        write_strategy(modes[s]);
        run_random_mix(120);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = STRAT_AREA;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_NOP;
    rect_min_x_i = '0;
    rect_min_y_i = '0;
    rect_max_x_i = '0;
    rect_max_y_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_full_table();
    test_random_traffic();
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rcs_pkg.sv
hw/rtl/rtree_choose_subtree.sv
bench/rtree_choose_subtree_tb.sv
